// ----- sv/calu_pkg.sv -----
package calu_pkg;

   localparam int FuncWidth = 4;
   localparam int CapWidth  = 5;

   localparam logic [CapWidth-1:0] CapReset = 5'd16;

   localparam logic [FuncWidth-1:0] FuncAppend = 4'd0;
   localparam logic [FuncWidth-1:0] FuncInsert = 4'd1;
   localparam logic [FuncWidth-1:0] FuncRemove = 4'd2;
   localparam logic [FuncWidth-1:0] FuncClear  = 4'd3;
   localparam logic [FuncWidth-1:0] FuncStart  = 4'd4;
   localparam logic [FuncWidth-1:0] FuncEnd    = 4'd5;
   localparam logic [FuncWidth-1:0] FuncNext   = 4'd6;
   localparam logic [FuncWidth-1:0] FuncPrev   = 4'd7;
   localparam logic [FuncWidth-1:0] FuncSetPos = 4'd8;
   localparam logic [FuncWidth-1:0] FuncRead   = 4'd9;

   typedef struct packed {
      logic [FuncWidth-1:0] func;
      logic signed [31:0]   value;
      logic [3:0]           position;
   } calu_req_type;

   typedef struct packed {
      logic               ok;
      logic signed [31:0] data_out;
      logic [3:0]         cursor_out;
      logic [4:0]         count_out;
      logic               is_empty;
      logic               is_full;
   } calu_rsp_type;

   typedef struct packed {
      logic load;
      logic decode;
      logic shift_init;
      logic shift_step;
      logic write_value;
      logic remove_finish;
      logic emit;
   } calu_cmd_type;

   typedef struct packed {
      logic append_go;
      logic insert_go;
      logic remove_go;
      logic is_insert;
      logic shift_done;
      logic out_free;
   } calu_status_type;

endpackage

// ----- sv/calu_ram.sv -----
module calu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                             wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                             rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/calu_dpath.sv -----
module calu_dpath #(
   parameter int CAPACITY = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  calu_pkg::calu_cmd_type             cmd,
   output calu_pkg::calu_status_type          status,
   input  calu_pkg::calu_req_type             req_data,
   input  logic                               csr_we,
   input  logic [calu_pkg::CapWidth-1:0]      csr_wdata,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output calu_pkg::calu_rsp_type             rsp_data
);

   import calu_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   logic [FuncWidth-1:0] func_ff;
   logic signed [31:0]   value_ff;
   logic [3:0]           pos_ff;
   logic [CW-1:0]        count_ff;
   logic [AW-1:0]        cursor_ff;
   logic [CapWidth-1:0]  cap_ff;
   logic                 ok_ff;
   logic [31:0]          removed_ff;
   logic [CW-1:0]        idx_ff;
   logic                 active_ff;
   logic                 pend_ff;
   logic [AW-1:0]        waddr_ff;
   logic                 rsp_valid_ff;
   calu_rsp_type         rsp_ff;
   calu_rsp_type         rsp_in;

   logic [31:0] count_w, cursor_w, pos_w, cap_w, idx_w, eff_cap;
   logic        full, cur_valid, ins;
   logic [CW-1:0] dec_count;
   logic [AW-1:0] dec_cursor;
   logic          dec_ok;

   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [31:0]   ram_wdata, ram_rdata;

   assign count_w  = 32'(count_ff);
   assign cursor_w = 32'(cursor_ff);
   assign pos_w    = 32'(pos_ff);
   assign cap_w    = 32'(cap_ff);
   assign idx_w    = 32'(idx_ff);

   always_comb begin
      if (cap_w == 32'd0) begin
         eff_cap = 32'd1;
      end else if (cap_w > 32'(CAPACITY)) begin
         eff_cap = 32'(CAPACITY);
      end else begin
         eff_cap = cap_w;
      end
   end

   assign full      = count_w >= eff_cap;
   assign cur_valid = cursor_w < count_w;
   assign ins       = func_ff == FuncInsert;

   assign status.append_go  = (func_ff == FuncAppend) && !full;
   assign status.insert_go  = ins && !full && cur_valid;
   assign status.remove_go  = (func_ff == FuncRemove) && cur_valid;
   assign status.is_insert  = ins;
   assign status.shift_done = !active_ff && !pend_ff;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   // cursor moves and clear for commands that touch no entry, and the ok flag for every command
   always_comb begin
      dec_count  = count_ff;
      dec_cursor = cursor_ff;
      dec_ok     = 1'b1;
      case (func_ff)
         FuncAppend: dec_ok = status.append_go;
         FuncInsert: dec_ok = status.insert_go;
         FuncRemove: dec_ok = status.remove_go;
         FuncClear: begin
            dec_count  = '0;
            dec_cursor = '0;
         end
         FuncStart: dec_cursor = '0;
         FuncEnd: begin
            if (count_w != 32'd0) begin
               dec_cursor = AW'(count_w - 32'd1);
            end
         end
         FuncNext: begin
            if (cursor_w + 32'd1 < count_w) begin
               dec_cursor = AW'(cursor_w + 32'd1);
            end
         end
         FuncPrev: begin
            if (cursor_w != 32'd0) begin
               dec_cursor = AW'(cursor_w - 32'd1);
            end
         end
         FuncSetPos: begin
            if (pos_w < count_w) begin
               dec_cursor = AW'(pos_w);
            end
         end
         FuncRead: dec_ok = 1'b1;
         default: dec_ok = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         cursor_ff <= '0;
         cap_ff    <= CapReset;
         active_ff <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
         if (cmd.decode) begin
            count_ff  <= dec_count;
            cursor_ff <= dec_cursor;
         end
         if (cmd.write_value) begin
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.remove_finish) begin
            count_ff <= count_ff - CW'(1);
         end
         if (cmd.shift_init) begin
            pend_ff <= 1'b0;
            if (ins) begin
               active_ff <= 1'b1;
            end else begin
               active_ff <= (cursor_w + 32'd1) < count_w;
            end
         end
         if (cmd.shift_step) begin
            pend_ff <= active_ff;
            // drop out after the last entry of the moving range
            if (active_ff) begin
               if (ins ? (idx_w == cursor_w) : (idx_w + 32'd1 == count_w)) begin
                  active_ff <= 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_data.func;
         value_ff <= req_data.value;
         pos_ff   <= req_data.position;
      end
      if (cmd.decode) begin
         ok_ff <= dec_ok;
      end
      if (cmd.shift_init) begin
         if (ins) begin
            idx_ff <= count_ff - CW'(1);
         end else begin
            removed_ff <= ram_rdata;
            idx_ff     <= CW'(cursor_w + 32'd1);
         end
      end
      if (cmd.shift_step) begin
         waddr_ff <= ins ? AW'(idx_w + 32'd1) : AW'(idx_w - 32'd1);
         if (active_ff) begin
            idx_ff <= ins ? (idx_ff - CW'(1)) : (idx_ff + CW'(1));
         end
      end
   end

   // read one entry ahead while the previous one lands one slot over
   always_comb begin
      ram_raddr = cmd.shift_step ? idx_ff[AW-1:0] : cursor_ff;
      ram_we    = (cmd.shift_step && pend_ff) || cmd.write_value;
      if (cmd.write_value) begin
         ram_waddr = (func_ff == FuncAppend) ? AW'(count_w) : cursor_ff;
         ram_wdata = value_ff;
      end else begin
         ram_waddr = waddr_ff;
         ram_wdata = ram_rdata;
      end
   end

   calu_ram #(
      .WIDTH(32),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      rsp_in.ok = ok_ff;
      if (ok_ff && (func_ff == FuncRemove)) begin
         rsp_in.data_out = removed_ff;
      end else if (cur_valid) begin
         rsp_in.data_out = ram_rdata;
      end else begin
         rsp_in.data_out = '0;
      end
      rsp_in.cursor_out = cursor_w[3:0];
      rsp_in.count_out  = count_w[4:0];
      rsp_in.is_empty   = count_w == 32'd0;
      rsp_in.is_full    = full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- sv/calu_ctrl.sv -----
module calu_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  calu_pkg::calu_status_type status,
   output calu_pkg::calu_cmd_type    cmd
);

   import calu_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_DECODE  = 7'b0000010,
      ST_CAPTURE = 7'b0000100,
      ST_SHIFT   = 7'b0001000,
      ST_WRITE   = 7'b0010000,
      ST_FETCH   = 7'b0100000,
      ST_RESULT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            if (status.append_go) begin
               state_in = ST_WRITE;
            end else if (status.insert_go) begin
               cmd.shift_init = 1'b1;
               state_in       = ST_SHIFT;
            end else if (status.remove_go) begin
               state_in = ST_CAPTURE;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_CAPTURE: begin
            cmd.shift_init = 1'b1;
            state_in       = ST_SHIFT;
         end
         ST_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (status.shift_done) begin
               if (status.is_insert) begin
                  state_in = ST_WRITE;
               end else begin
                  cmd.remove_finish = 1'b1;
                  state_in          = ST_FETCH;
               end
            end
         end
         ST_WRITE: begin
            cmd.write_value = 1'b1;
            state_in        = ST_FETCH;
         end
         ST_FETCH: state_in = ST_RESULT;
         ST_RESULT: begin
            // hold until the output register is free
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;

endmodule

// ----- sv/cursor_array_list_unit.sv -----
// Each command is taken in IDLE and decoded in DECODE. Cursor, read and refused commands then
// pass FETCH and RESULT; append passes WRITE first. Insert moves count - cursor entries in
// SHIFT, then WRITE; remove passes CAPTURE, then moves count - cursor - 1 entries in SHIFT.
// One item at a time: the next beat is taken in the cycle after the result is loaded, and an
// item waits in RESULT while the previous result is held.
// Synchronous active-high reset empties the list, zeroes the cursor, sets capacity 16.
module cursor_array_list_unit #(
   parameter int CAPACITY = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  calu_pkg::calu_req_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output calu_pkg::calu_rsp_type        rsp_data,
   input  logic                          csr_we,
   input  logic [calu_pkg::CapWidth-1:0] csr_wdata
);

   import calu_pkg::*;

   calu_cmd_type    cmd;
   calu_status_type status;

   calu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   calu_dpath #(
      .CAPACITY(CAPACITY)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- sv/calu_checker.sv -----
module calu_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input calu_pkg::calu_rsp_type rsp_data
);

   import calu_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second beat taken while an item is in flight");

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, rsp_data.cursor_out} <= rsp_data.count_out)
      else $error("cursor past the end of the list");

   a_empty_cursor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_empty |-> rsp_data.cursor_out == 4'd0)
      else $error("cursor off zero on an empty list");

   a_empty_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_empty |-> !rsp_data.is_full)
      else $error("list reported empty and full at once");

endmodule

bind cursor_array_list_unit calu_checker u_calu_checker (.*);
